### rtl/ppue_pkg.sv
package ppue_pkg;

  localparam int unsigned Capacity = 1024;
  localparam int unsigned IdxW     = $clog2(Capacity);
  localparam int unsigned CntW     = $clog2(Capacity + 1);
  localparam int unsigned OutCntW  = 11;
  localparam int unsigned CfgIdxW  = 1;

  localparam logic [CfgIdxW-1:0] CfgStartColor = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgEndColor   = 1'b1;

  localparam logic CmdAdd    = 1'b0;
  localparam logic CmdUpdate = 1'b1;

  typedef struct packed {
    logic               cmd;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic        [31:0] life_span;
    logic        [31:0] time_step;
  } ppue_in_t;

  typedef struct packed {
    logic               accepted;
    logic [OutCntW-1:0] live_count;
  } ppue_out_t;

  // one particle record as it sits in the store
  typedef struct packed {
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] pz;
    logic [31:0] vx;
    logic [31:0] vy;
    logic [31:0] vz;
    logic [31:0] life;
    logic [63:0] col;
  } ppue_rec_t;

  localparam int unsigned RecW = $bits(ppue_rec_t);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ADD,
    ST_RD,
    ST_WAIT,
    ST_CHECK,
    ST_MUL,
    ST_DIV,
    ST_WB,
    ST_MOVE_RD,
    ST_MOVE_WAIT,
    ST_MOVE_WB,
    ST_DONE
  } ppue_state_e;

  // controller to datapath
  typedef struct packed {
    logic load_in;
    logic add_wr;
    logic rd_cur;
    logic rd_last;
    logic mul_go;
    logic div_go;
    logic upd_wr;
    logic move_wr;
    logic cnt_dec;
    logic idx_inc;
    logic idx_clr;
    logic res_ld;
  } ppue_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic full;
    logic walk_end;
    logic expired;
    logic div_busy;
    logic is_last;
  } ppue_stat_t;

endpackage

### rtl/ppue_ram.sv
module ppue_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/ppue_div.sv
module ppue_div
  import ppue_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [47:0] num_i,
  input  logic [31:0] den_i,
  output logic        busy_o,
  output logic [47:0] quo_o
);

  // restoring divider, one quotient bit per cycle
  logic [47:0] quo_q, quo_d;
  logic [32:0] rem_q, rem_d;
  logic [31:0] den_q, den_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic [32:0] trial;

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    trial  = {rem_q[31:0], quo_q[47]} - {1'b0, den_q};
    if (start_i) begin
      quo_d  = num_i;
      rem_d  = '0;
      den_d  = den_i;
      cnt_d  = 6'd48;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[32]) begin
        rem_d = trial;
        quo_d = {quo_q[46:0], 1'b1};
      end else begin
        rem_d = {rem_q[31:0], quo_q[47]};
        quo_d = {quo_q[46:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign busy_o = busy_q;
  assign quo_o  = quo_q;

endmodule

### rtl/ppue_datapath.sv
module ppue_datapath
  import ppue_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  ppue_cmd_t     cmd_i,
  output ppue_stat_t    stat_o,
  input  ppue_in_t      in_i,
  input  logic          cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [63:0]   cfg_data_i,
  output logic [CntW-1:0] count_o
);

  logic [63:0]     start_q, end_q;
  ppue_in_t        in_q;
  logic [CntW-1:0] count_q;
  logic [CntW-1:0] res_cnt_q;
  logic [CntW-1:0] idx_q;
  ppue_rec_t       rd_rec, rec_q, wr_rec;
  logic            we;
  logic [IdxW-1:0] waddr, raddr, last_idx;
  logic [31:0]     life_q;
  logic [63:0]     prod_x_q, prod_y_q, prod_z_q;
  logic [1:0]      ch_q;
  logic [63:0]     col_q;
  logic [3:0][16:0] diff_q;
  logic            div_busy, div_busy_q;
  logic [47:0]     quo, num;
  logic [16:0]     dch;
  logic [15:0]     mag;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q   <= '0;
      end_q     <= '0;
      count_q   <= '0;
      res_cnt_q <= '0;
      idx_q     <= '0;
    end else begin
      if (cfg_we_i && cfg_idx_i == CfgStartColor) start_q <= cfg_data_i;
      if (cfg_we_i && cfg_idx_i == CfgEndColor)   end_q   <= cfg_data_i;
      if (cmd_i.add_wr) count_q <= count_q + 1'b1;
      else if (cmd_i.cnt_dec) count_q <= count_q - 1'b1;
      if (cmd_i.idx_clr) idx_q <= '0;
      else if (cmd_i.idx_inc) idx_q <= idx_q + 1'b1;
      // count as seen by the result, held while the next item runs
      if (cmd_i.res_ld) res_cnt_q <= count_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) in_q <= in_i;
  end

  assign last_idx = IdxW'(count_q - 1'b1);
  assign raddr    = cmd_i.rd_last ? last_idx : idx_q[IdxW-1:0];

  ppue_ram #(.Width(RecW), .Depth(Capacity)) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wr_rec),
    .raddr_i (raddr),
    .rdata_o (rd_rec)
  );

  // saturating position add
  function automatic logic [31:0] pos_add(logic [31:0] p, logic [63:0] prod);
    logic signed [47:0] d;
    logic signed [48:0] s;
    d = $signed(prod[63:16]);
    s = 49'($signed(p)) + 49'(d);
    if (s > 49'sd2147483647) return 32'h7fffffff;
    if (s < -49'sd2147483648) return 32'h80000000;
    return s[31:0];
  endfunction

  always_comb begin
    dch = diff_q[ch_q];
    mag = dch[16] ? 16'(-dch) : dch[15:0];
    num = 48'(mag) * 48'(in_q.time_step);
  end

  ppue_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_go),
    .num_i   (num),
    .den_i   (life_q),
    .busy_o  (div_busy),
    .quo_o   (quo)
  );

  always_ff @(posedge clk_i) begin
    logic signed [49:0] c;
    div_busy_q <= div_busy;
    if (cmd_i.rd_cur || cmd_i.move_wr) begin
      ch_q <= '0;
    end
    if (cmd_i.mul_go) begin
      rec_q    <= rd_rec;
      life_q   <= rd_rec.life - in_q.time_step;
      col_q    <= rd_rec.col;
      prod_x_q <= 64'($signed(rd_rec.vx)) * 64'(in_q.time_step);
      prod_y_q <= 64'($signed(rd_rec.vy)) * 64'(in_q.time_step);
      prod_z_q <= 64'($signed(rd_rec.vz)) * 64'(in_q.time_step);
      for (int k = 0; k < 4; k++) begin
        diff_q[k] <= {1'b0, end_q[16*k +: 16]} - {1'b0, start_q[16*k +: 16]};
      end
      ch_q <= '0;
    end
    // apply quotient when the divider finishes
    if (div_busy_q && !div_busy) begin
      c = 50'(col_q[16*ch_q +: 16]);
      if (dch[16]) c = c - 50'(quo);
      else c = c + 50'(quo);
      if (c < 0) col_q[16*ch_q +: 16] <= 16'h0000;
      else if (c > 50'sd65535) col_q[16*ch_q +: 16] <= 16'hffff;
      else col_q[16*ch_q +: 16] <= c[15:0];
      ch_q <= ch_q + 2'd1;
    end
  end

  always_comb begin
    we     = 1'b0;
    waddr  = idx_q[IdxW-1:0];
    wr_rec = rd_rec;
    if (cmd_i.add_wr) begin
      we     = 1'b1;
      waddr  = count_q[IdxW-1:0];
      wr_rec = '{px: in_q.pos_x, py: in_q.pos_y, pz: in_q.pos_z,
                 vx: in_q.vel_x, vy: in_q.vel_y, vz: in_q.vel_z,
                 life: in_q.life_span, col: start_q};
    end else if (cmd_i.upd_wr) begin
      we     = 1'b1;
      wr_rec = rec_q;
      wr_rec.px   = pos_add(rec_q.px, prod_x_q);
      wr_rec.py   = pos_add(rec_q.py, prod_y_q);
      wr_rec.pz   = pos_add(rec_q.pz, prod_z_q);
      wr_rec.life = life_q;
      wr_rec.col  = col_q;
    end else if (cmd_i.move_wr) begin
      we = 1'b1;
    end
  end

  assign stat_o.full     = (count_q >= CntW'(Capacity));
  assign stat_o.walk_end = (idx_q >= count_q);
  assign stat_o.expired  = (rd_rec.life <= in_q.time_step);
  assign stat_o.div_busy = div_busy || (div_busy_q && !div_busy);
  assign stat_o.is_last  = (idx_q[IdxW-1:0] == last_idx);
  assign count_o         = res_cnt_q;

endmodule

### rtl/ppue_ctrl.sv
module ppue_ctrl
  import ppue_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_cmd_i,
  output logic       in_stall_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       out_accepted_o,
  output ppue_cmd_t  cmd_o,
  input  ppue_stat_t stat_i
);

  ppue_state_e state_q, state_d;
  logic        is_upd_q, is_upd_d;
  logic [1:0]  ch_q, ch_d;
  logic        ovalid_q, ovalid_d;
  logic        oacc_q, oacc_d;
  logic        res_acc_q, res_acc_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      is_upd_q  <= 1'b0;
      ch_q      <= '0;
      ovalid_q  <= 1'b0;
      oacc_q    <= 1'b0;
      res_acc_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      is_upd_q  <= is_upd_d;
      ch_q      <= ch_d;
      ovalid_q  <= ovalid_d;
      oacc_q    <= oacc_d;
      res_acc_q <= res_acc_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    is_upd_d  = is_upd_q;
    ch_d      = ch_q;
    ovalid_d  = ovalid_q;
    oacc_d    = oacc_q;
    res_acc_d = res_acc_q;
    cmd_o     = '0;
    in_stall_o = 1'b1;
    if (ovalid_q && !out_stall_i) ovalid_d = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          cmd_o.idx_clr = 1'b1;
          is_upd_d = (in_cmd_i == CmdUpdate);
          state_d  = (in_cmd_i == CmdUpdate) ? ST_RD : ST_ADD;
        end
      end
      ST_ADD: begin
        cmd_o.add_wr = !stat_i.full;
        oacc_d  = !stat_i.full;
        state_d = ST_DONE;
      end
      ST_RD: begin
        if (stat_i.walk_end) begin
          oacc_d  = 1'b1;
          state_d = ST_DONE;
        end else begin
          cmd_o.rd_cur = 1'b1;
          state_d = ST_WAIT;
        end
      end
      ST_WAIT: state_d = ST_CHECK;
      ST_CHECK: begin
        if (stat_i.expired) begin
          state_d = stat_i.is_last ? ST_MOVE_WB : ST_MOVE_RD;
        end else begin
          cmd_o.mul_go = 1'b1;
          ch_d    = '0;
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd_o.div_go = 1'b1;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        if (!stat_i.div_busy) begin
          if (ch_q == 2'd3) begin
            state_d = ST_WB;
          end else begin
            ch_d = ch_q + 2'd1;
            cmd_o.div_go = 1'b1;
          end
        end
      end
      ST_WB: begin
        cmd_o.upd_wr  = 1'b1;
        cmd_o.idx_inc = 1'b1;
        state_d = ST_RD;
      end
      ST_MOVE_RD: begin
        cmd_o.rd_last = 1'b1;
        state_d = ST_MOVE_WAIT;
      end
      ST_MOVE_WAIT: begin
        cmd_o.move_wr = 1'b1;
        state_d = ST_MOVE_WB;
      end
      ST_MOVE_WB: begin
        // slot is handled again with the moved record
        cmd_o.cnt_dec = 1'b1;
        state_d = ST_RD;
      end
      ST_DONE: begin
        if (!ovalid_q || !out_stall_i) begin
          ovalid_d     = 1'b1;
          res_acc_d    = oacc_q;
          cmd_o.res_ld = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_o    = ovalid_q;
  assign out_accepted_o = res_acc_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> is_upd_q)
    else $error("divider running outside an update");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.add_wr |-> !stat_i.full)
    else $error("add written into a full pool");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovalid_q && out_stall_i) |=> ovalid_q)
    else $error("result dropped while stalled");

endmodule

### rtl/particle_pool_update_engine_top.sv
// channel | valid      | stall       | payload
// input   | in_valid_i | in_stall_o  | in_data_i  (ppue_in_t)
// output  | out_valid_o| out_stall_i | out_data_o (ppue_out_t)
// config  | cfg_we_i   | -           | cfg_idx_i, cfg_data_i
// add writes one record; update walks every live particle, running the
// 48-step divider once per colour channel for each particle that survives;
// an expired particle is replaced by the last record, or dropped if it is last.
// one item at a time; the result register frees the input side once loaded.
// reset clears count and colour registers; the particle store is not cleared.
module particle_pool_update_engine_top
  import ppue_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  ppue_in_t           in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output ppue_out_t          out_data_o,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [63:0]        cfg_data_i
);

  ppue_cmd_t       cmd;
  ppue_stat_t      stat;
  logic [CntW-1:0] count;
  logic            acc;

  ppue_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_cmd_i       (in_data_i.cmd),
    .in_stall_o     (in_stall_o),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_accepted_o (acc),
    .cmd_o          (cmd),
    .stat_i         (stat)
  );

  ppue_datapath u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .in_i       (in_data_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .count_o    (count)
  );

  assign out_data_o.accepted   = acc;
  assign out_data_o.live_count = OutCntW'(count);

endmodule
